[rtl/multilevel_queue_scheduler_top_defines.svh]
// assertion macros for the multilevel queue scheduler
`ifndef MULTILEVEL_QUEUE_SCHEDULER_TOP_DEFINES_SVH
`define MULTILEVEL_QUEUE_SCHEDULER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// checked property, disabled while reset is applied
`define MLQS_ASSERT(lbl, ck, rn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error("mlqs check failed");
// checked property, also during reset
`define MLQS_ASSERT_ALWAYS(lbl, ck, prop) \
  lbl: assert property (@(posedge ck) prop) else $error("mlqs check failed");
`else
`define MLQS_ASSERT(lbl, ck, rn, prop)
`define MLQS_ASSERT_ALWAYS(lbl, ck, prop)
`endif

`endif

[rtl/mlqs_pkg.sv]
// types and constants of the multilevel queue scheduler
`timescale 1ns / 1ps
package mlqs_pkg;

  localparam int MAX_PROCS  = 64;
  localparam int ID_W       = 6;
  localparam int CNT_W      = 7;
  localparam int BURST_BITS = 16;
  localparam int PRIO_W     = 4;
  localparam int ENT_W      = PRIO_W + ID_W;

  localparam logic [PRIO_W-1:0] PRIO_MAX = 4'd9;
  localparam logic [CNT_W-1:0]  NO_PROC  = 7'd64;
  localparam logic [CNT_W-1:0]  CNT_FULL = 7'd64;

  localparam logic CMD_ARRIVE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  localparam logic [1:0] CFG_QUANTUM  = 2'd0;
  localparam logic [1:0] CFG_BUDGET   = 2'd1;
  localparam logic [1:0] CFG_TOP_BAND = 2'd2;
  localparam logic [1:0] CFG_MID_BAND = 2'd3;

  typedef enum logic [1:0] {
    LVL_TOP = 2'd0,
    LVL_MID = 2'd1,
    LVL_LOW = 2'd2
  } level_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD,
    S_EXEC,
    S_MS_RD,
    S_MS_WR,
    S_INS_RD,
    S_INS_CMP
  } state_t;

  function automatic level_t next_level(input level_t l);
    level_t r;
    case (l)
      LVL_TOP: r = LVL_MID;
      LVL_MID: r = LVL_LOW;
      default: r = LVL_TOP;
    endcase
    return r;
  endfunction

endpackage

[rtl/multilevel_queue_scheduler_top.sv]
// multilevel queue scheduler: round-robin, sorted and fcfs levels in block memories
//
// channel | ports                                   | beat
// --------+-----------------------------------------+------------------------------
// in      | start, busy, in_cmd/proc_id/prio/burst  | start & !busy
// out     | out_valid, out_status ... out_time_now  | out_valid, one cycle, no stall
// cfg     | cfg_valid, cfg_ready, cfg_index, data   | cfg_valid & cfg_ready
//
// a tick steps through head read, work read and execute; a middle-level completion
// adds a shift-down of the remaining entries of the n-entry sorted list
// a top/low arrival completes in the idle state; a middle arrival walks the sorted list from its
// tail, reading and comparing each entry and moving it up until the new entry's slot is found
// the result beat comes in the cycle after its decision; the receiver cannot stall
// synchronous active-low reset clears counters, heads, the queued-id bitmap and the control
// registers, config to its defaults; the payload registers and the memories are not cleared
`timescale 1ns / 1ps
`include "multilevel_queue_scheduler_top_defines.svh"
module multilevel_queue_scheduler_top
  import mlqs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_cmd,
  input  logic [ID_W-1:0]       in_proc_id,
  input  logic [PRIO_W-1:0]     in_prio_level,
  input  logic [BURST_BITS-1:0] in_burst_len,
  output logic                  out_valid,
  output logic                  out_status,
  output logic                  out_ran_valid,
  output logic [ID_W-1:0]       out_ran_id,
  output logic                  out_switched,
  output logic                  out_finished,
  output logic [31:0]           out_time_now,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [3:0]            cfg_data
);

  // storage: per-id remaining work, two fifos and the sorted middle list
  logic [BURST_BITS-1:0] rem_mem [MAX_PROCS];
  logic [ID_W-1:0]       top_mem [MAX_PROCS];
  logic [ENT_W-1:0]      mid_mem [MAX_PROCS];
  logic [ID_W-1:0]       low_mem [MAX_PROCS];

  logic [BURST_BITS-1:0] rem_rd_r;
  logic [ID_W-1:0]       top_rd_r, low_rd_r;
  logic [ENT_W-1:0]      mid_rd_r;

  // memory port controls
  logic                  rem_we, top_we, mid_we, low_we;
  logic [ID_W-1:0]       rem_waddr, top_waddr, mid_waddr, low_waddr;
  logic [BURST_BITS-1:0] rem_wdata;
  logic [ID_W-1:0]       top_wdata, low_wdata;
  logic [ENT_W-1:0]      mid_wdata;
  logic [ID_W-1:0]       mid_raddr, head_id;

  state_t state_r, state_nxt;
  level_t active_r, active_nxt, lvl_r, lvl_nxt;

  logic [3:0]       quantum_len_r, level_budget_r, top_band_r, mid_band_r;
  logic [3:0]       level_ticks_r, level_ticks_nxt, quantum_ticks_r, quantum_ticks_nxt;
  logic [31:0]      time_r, time_nxt;
  logic [CNT_W-1:0] last_ran_r, last_ran_nxt;
  logic [ID_W-1:0]  top_head_r, top_head_nxt, low_head_r, low_head_nxt;
  logic [CNT_W-1:0] top_count_r, top_count_nxt, mid_count_r, mid_count_nxt;
  logic [CNT_W-1:0] low_count_r, low_count_nxt;
  logic [MAX_PROCS-1:0] queued_r, queued_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [ENT_W-1:0] new_ent_r, new_ent_nxt;
  logic [ID_W-1:0]  id_r, id_nxt;

  logic             out_valid_r, out_valid_nxt, out_status_r, out_status_nxt;
  logic             out_ran_r, out_ran_nxt, out_sw_r, out_sw_nxt, out_fin_r, out_fin_nxt;
  logic [ID_W-1:0]  out_id_r, out_id_nxt;
  logic [31:0]      out_time_r, out_time_nxt;

  // shared decisions
  logic [3:0]       budget, quantum, qt_inc;
  logic             turn_over, tick_none;
  level_t           cand1, cand2, tick_lvl;
  level_t           arr_lvl;
  logic             arr_reject;
  logic [BURST_BITS-1:0] rem_dec;
  logic             fin;
  logic             ins_shift;

  function automatic logic [CNT_W-1:0] lvl_cnt(input level_t l, input logic [CNT_W-1:0] t,
                                               input logic [CNT_W-1:0] m,
                                               input logic [CNT_W-1:0] w);
    logic [CNT_W-1:0] r;
    case (l)
      LVL_TOP: r = t;
      LVL_MID: r = m;
      default: r = w;
    endcase
    return r;
  endfunction

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  // zero registers act as one
  assign budget  = (level_budget_r == 4'd0) ? 4'd1 : level_budget_r;
  assign quantum = (quantum_len_r == 4'd0) ? 4'd1 : quantum_len_r;
  assign qt_inc  = quantum_ticks_r + 4'd1;

  // turn selection: stay, else next non-empty level with the current one last
  assign cand1     = next_level(active_r);
  assign cand2     = next_level(cand1);
  assign turn_over = (level_ticks_r >= budget) ||
                     (lvl_cnt(active_r, top_count_r, mid_count_r, low_count_r) == '0);
  always_comb begin
    tick_none = 1'b0;
    tick_lvl  = active_r;
    if (turn_over) begin
      if (lvl_cnt(cand1, top_count_r, mid_count_r, low_count_r) != '0) begin
        tick_lvl = cand1;
      end else if (lvl_cnt(cand2, top_count_r, mid_count_r, low_count_r) != '0) begin
        tick_lvl = cand2;
      end else if (lvl_cnt(active_r, top_count_r, mid_count_r, low_count_r) == '0) begin
        tick_none = 1'b1;
      end
    end
  end

  // arrival checks: band, range, zero burst, full level, already queued
  always_comb begin
    if (in_prio_level <= top_band_r) begin
      arr_lvl = LVL_TOP;
    end else if (in_prio_level <= mid_band_r) begin
      arr_lvl = LVL_MID;
    end else begin
      arr_lvl = LVL_LOW;
    end
    arr_reject = (in_prio_level == '0) || (in_prio_level > PRIO_MAX) ||
                 (in_burst_len == '0) ||
                 (lvl_cnt(arr_lvl, top_count_r, mid_count_r, low_count_r) >= CNT_FULL) ||
                 queued_r[in_proc_id];
  end

  assign rem_dec   = rem_rd_r - {{(BURST_BITS-1){1'b0}}, 1'b1};
  assign fin       = (rem_dec == '0);
  assign ins_shift = (mid_rd_r[ENT_W-1:ID_W] > new_ent_r[ENT_W-1:ID_W]);

  always_comb begin
    case (lvl_r)
      LVL_TOP: head_id = top_rd_r;
      LVL_MID: head_id = mid_rd_r[ID_W-1:0];
      default: head_id = low_rd_r;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_cmd == CMD_TICK) begin
            if (!tick_none) state_nxt = S_HEAD;
          end else if (!arr_reject && arr_lvl == LVL_MID) begin
            state_nxt = S_INS_RD;
          end
        end
      end
      S_HEAD: state_nxt = S_EXEC;
      S_EXEC: begin
        if (lvl_r == LVL_MID && fin && mid_count_r > 7'd1) state_nxt = S_MS_RD;
        else state_nxt = S_IDLE;
      end
      S_MS_RD: state_nxt = S_MS_WR;
      S_MS_WR: begin
        if (idx_r < mid_count_r) state_nxt = S_MS_RD;
        else state_nxt = S_IDLE;
      end
      S_INS_RD: begin
        if (idx_r == '0) state_nxt = S_IDLE;
        else state_nxt = S_INS_CMP;
      end
      S_INS_CMP: begin
        if (ins_shift) state_nxt = S_INS_RD;
        else state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    active_nxt        = active_r;
    lvl_nxt           = lvl_r;
    level_ticks_nxt   = level_ticks_r;
    quantum_ticks_nxt = quantum_ticks_r;
    time_nxt          = time_r;
    last_ran_nxt      = last_ran_r;
    top_head_nxt      = top_head_r;
    top_count_nxt     = top_count_r;
    mid_count_nxt     = mid_count_r;
    low_head_nxt      = low_head_r;
    low_count_nxt     = low_count_r;
    queued_nxt        = queued_r;
    idx_nxt           = idx_r;
    new_ent_nxt       = new_ent_r;
    id_nxt            = id_r;
    out_valid_nxt     = 1'b0;
    out_status_nxt    = out_status_r;
    out_ran_nxt       = out_ran_r;
    out_id_nxt        = out_id_r;
    out_sw_nxt        = out_sw_r;
    out_fin_nxt       = out_fin_r;
    out_time_nxt      = out_time_r;
    rem_we = 1'b0; rem_waddr = id_r; rem_wdata = rem_dec;
    top_we = 1'b0; top_waddr = top_head_r + top_count_r[ID_W-1:0]; top_wdata = id_r;
    low_we = 1'b0; low_waddr = low_head_r + low_count_r[ID_W-1:0]; low_wdata = in_proc_id;
    mid_we = 1'b0; mid_waddr = idx_r[ID_W-1:0]; mid_wdata = new_ent_r;
    mid_raddr = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start && in_cmd == CMD_ARRIVE) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = arr_reject;
          out_ran_nxt    = 1'b0;
          out_id_nxt     = '0;
          out_sw_nxt     = 1'b0;
          out_fin_nxt    = 1'b0;
          out_time_nxt   = time_r;
          if (!arr_reject) begin
            rem_we                 = 1'b1;
            rem_waddr              = in_proc_id;
            rem_wdata              = in_burst_len;
            queued_nxt[in_proc_id] = 1'b1;
            case (arr_lvl)
              LVL_TOP: begin
                top_we        = 1'b1;
                top_wdata     = in_proc_id;
                top_count_nxt = top_count_r + 7'd1;
              end
              LVL_MID: begin
                new_ent_nxt = {in_prio_level, in_proc_id};
                idx_nxt     = mid_count_r;
              end
              default: begin
                low_we        = 1'b1;
                low_count_nxt = low_count_r + 7'd1;
              end
            endcase
          end
        end else if (start) begin
          if (tick_none) begin
            // idle tick: time moves, turn restarts at the top
            time_nxt          = time_r + 32'd1;
            active_nxt        = LVL_TOP;
            level_ticks_nxt   = '0;
            quantum_ticks_nxt = '0;
            out_valid_nxt     = 1'b1;
            out_status_nxt    = 1'b0;
            out_ran_nxt       = 1'b0;
            out_id_nxt        = '0;
            out_sw_nxt        = 1'b0;
            out_fin_nxt       = 1'b0;
            out_time_nxt      = time_r + 32'd1;
          end else begin
            lvl_nxt    = tick_lvl;
            active_nxt = tick_lvl;
            if (turn_over) begin
              level_ticks_nxt = '0;
              if (tick_lvl == LVL_TOP) quantum_ticks_nxt = '0;
            end
          end
        end
      end
      S_HEAD: id_nxt = head_id;
      S_EXEC: begin
        rem_we          = 1'b1;
        last_ran_nxt    = {1'b0, id_r};
        level_ticks_nxt = level_ticks_r + 4'd1;
        time_nxt        = time_r + 32'd1;
        if (fin) queued_nxt[id_r] = 1'b0;
        case (lvl_r)
          LVL_TOP: begin
            if (fin) begin
              top_head_nxt      = top_head_r + 6'd1;
              top_count_nxt     = top_count_r - 7'd1;
              quantum_ticks_nxt = '0;
            end else if (qt_inc >= quantum) begin
              // quantum spent: head rotates to the tail slot
              top_we            = 1'b1;
              top_head_nxt      = top_head_r + 6'd1;
              quantum_ticks_nxt = '0;
            end else begin
              quantum_ticks_nxt = qt_inc;
            end
          end
          LVL_MID: begin
            if (fin) begin
              mid_count_nxt = mid_count_r - 7'd1;
              idx_nxt       = 7'd1;
            end
          end
          default: begin
            if (fin) begin
              low_head_nxt  = low_head_r + 6'd1;
              low_count_nxt = low_count_r - 7'd1;
            end
          end
        endcase
        out_valid_nxt  = 1'b1;
        out_status_nxt = 1'b0;
        out_ran_nxt    = 1'b1;
        out_id_nxt     = id_r;
        out_sw_nxt     = (last_ran_r != {1'b0, id_r});
        out_fin_nxt    = fin;
        out_time_nxt   = time_r + 32'd1;
      end
      S_MS_RD: mid_raddr = idx_r[ID_W-1:0];
      S_MS_WR: begin
        mid_we    = 1'b1;
        mid_waddr = idx_r[ID_W-1:0] - 6'd1;
        mid_wdata = mid_rd_r;
        idx_nxt   = idx_r + 7'd1;
      end
      S_INS_RD: begin
        mid_raddr = idx_r[ID_W-1:0] - 6'd1;
        if (idx_r == '0) begin
          mid_we        = 1'b1;
          mid_count_nxt = mid_count_r + 7'd1;
        end
      end
      S_INS_CMP: begin
        mid_we = 1'b1;
        if (ins_shift) begin
          mid_wdata = mid_rd_r;
          idx_nxt   = idx_r - 7'd1;
        end else begin
          mid_count_nxt = mid_count_r + 7'd1;
        end
      end
      default: ;
    endcase
  end

  // memories, one write and one registered read each
  always_ff @(posedge clk) begin
    if (rem_we) rem_mem[rem_waddr] <= rem_wdata;
    rem_rd_r <= rem_mem[head_id];
  end

  always_ff @(posedge clk) begin
    if (top_we) top_mem[top_waddr] <= top_wdata;
    top_rd_r <= top_mem[top_head_nxt];
  end

  always_ff @(posedge clk) begin
    if (mid_we) mid_mem[mid_waddr] <= mid_wdata;
    mid_rd_r <= mid_mem[mid_raddr];
  end

  always_ff @(posedge clk) begin
    if (low_we) low_mem[low_waddr] <= low_wdata;
    low_rd_r <= low_mem[low_head_nxt];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      active_r        <= LVL_TOP;
      lvl_r           <= LVL_TOP;
      level_ticks_r   <= '0;
      quantum_ticks_r <= '0;
      time_r          <= '0;
      last_ran_r      <= NO_PROC;
      top_head_r      <= '0;
      top_count_r     <= '0;
      mid_count_r     <= '0;
      low_head_r      <= '0;
      low_count_r     <= '0;
      queued_r        <= '0;
      out_valid_r     <= 1'b0;
      quantum_len_r   <= 4'd4;
      level_budget_r  <= 4'd10;
      top_band_r      <= 4'd3;
      mid_band_r      <= 4'd6;
    end else begin
      state_r         <= state_nxt;
      active_r        <= active_nxt;
      lvl_r           <= lvl_nxt;
      level_ticks_r   <= level_ticks_nxt;
      quantum_ticks_r <= quantum_ticks_nxt;
      time_r          <= time_nxt;
      last_ran_r      <= last_ran_nxt;
      top_head_r      <= top_head_nxt;
      top_count_r     <= top_count_nxt;
      mid_count_r     <= mid_count_nxt;
      low_head_r      <= low_head_nxt;
      low_count_r     <= low_count_nxt;
      queued_r        <= queued_nxt;
      out_valid_r     <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_QUANTUM:  quantum_len_r  <= cfg_data;
          CFG_BUDGET:   level_budget_r <= cfg_data;
          CFG_TOP_BAND: top_band_r     <= cfg_data;
          CFG_MID_BAND: mid_band_r     <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    new_ent_r    <= new_ent_nxt;
    id_r         <= id_nxt;
    out_status_r <= out_status_nxt;
    out_ran_r    <= out_ran_nxt;
    out_id_r     <= out_id_nxt;
    out_sw_r     <= out_sw_nxt;
    out_fin_r    <= out_fin_nxt;
    out_time_r   <= out_time_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_ran_valid = out_ran_r;
  assign out_ran_id    = out_id_r;
  assign out_switched  = out_sw_r;
  assign out_finished  = out_fin_r;
  assign out_time_now  = out_time_r;

  // checks
  `MLQS_ASSERT(a_exec_beat, clk, rst_n, (state_r == S_EXEC) |=> out_valid_r)
  `MLQS_ASSERT(a_tick_flow, clk, rst_n, (start && !busy && in_cmd == CMD_TICK) |=> (busy || out_valid_r))
  `MLQS_ASSERT(a_fin_ran, clk, rst_n, (out_valid_r && out_fin_r) |-> out_ran_r)
  `MLQS_ASSERT(a_rej_no_run, clk, rst_n, (out_valid_r && out_status_r) |-> !out_ran_r)
  `MLQS_ASSERT_ALWAYS(a_mid_bound, clk, (!rst_n || mid_count_r <= CNT_FULL))

endmodule
